### rtl/rnm_pkg.sv
// ----------------------------------------------------------------------------
// rnm_pkg
// Shared types and fixed widths for the radius neighborhood mean filter.
// ----------------------------------------------------------------------------
`default_nettype none

package rnm_pkg;

	localparam int RADIUS_W  = 25;
	localparam int NUMPTS_W  = 11;
	localparam int COUNT_W   = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 25'd1;
	localparam logic [NUMPTS_W-1:0] NUMPTS_RST = 11'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS_SQ  = 1'b0,
		REG_NUM_POINTS = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		REQ_LOAD  = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_LATCH,
		ST_WALK,
		ST_DRAIN,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### rtl/rnm_ram.sv
// ----------------------------------------------------------------------------
// rnm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rnm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/rnm_div.sv
// ----------------------------------------------------------------------------
// rnm_div
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rnm_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 11
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic        [DEN_W-1:0] den,
	output logic                         done,
	output logic signed      [NUM_W-1:0] quo
);

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W:0]   rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;

	logic [DEN_W:0]   rem_sh;
	logic             ge;
	logic [DEN_W:0]   rem_nx;
	logic [NUM_W-1:0] mag;

	always_comb begin
		rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
		mag    = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out of the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NUM_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

### rtl/radius_neighborhood_mean.sv
// ----------------------------------------------------------------------------
// radius_neighborhood_mean
// Point table in one RAM; a query walks the table, sums the samples of all
// points within the squared radius of the queried point and divides by count.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_ready   | req_type point_index coord_x coord_y sample_value
//  out     | out_valid / out_ready | smoothed_value neighbor_count empty_flag
//  cfg     | cfg_valid / cfg_ready | cfg_index cfg_data
//
//  A load writes its RAM entry at the accepting edge.
//  A query makes one RAM read per walked entry, then one divider step per
//  sum bit; a query with no neighbor skips the divider.
//  No request is taken while a query is in flight.
//  Reset clears control state and sets radius_sq to 1, num_points to 1024;
//  table contents are undefined until loaded. A stalled result sits in the
//  output register while loads keep going.
// ----------------------------------------------------------------------------
`default_nettype none

module radius_neighborhood_mean
	import rnm_pkg::*;
#(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 12,
	parameter int VALUE_BITS = 24
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  req_type,
	input  wire logic        [$clog2(MAX_POINTS)-1:0]  point_index,
	input  wire logic        [COORD_BITS-1:0]          coord_x,
	input  wire logic        [COORD_BITS-1:0]          coord_y,
	input  wire logic signed [VALUE_BITS-1:0]          sample_value,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed      [VALUE_BITS-1:0]          smoothed_value,
	output logic             [COUNT_W-1:0]             neighbor_count,
	output logic                                       empty_flag,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic        [CFG_IDX_W-1:0]           cfg_index,
	input  wire logic        [RADIUS_W-1:0]            cfg_data
);

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int WK_W   = IDX_W + 1;
	localparam int SUM_W  = VALUE_BITS + IDX_W + 1;
	localparam int ENT_W  = 2 * COORD_BITS + VALUE_BITS;
	localparam int SQ_W   = 2 * COORD_BITS;
	localparam int DST_W  = SQ_W + 1;
	localparam int CMP_W  = (DST_W > RADIUS_W) ? DST_W : RADIUS_W;
	localparam int WX_W   = (NUMPTS_W > WK_W) ? NUMPTS_W : WK_W;
	localparam int CX_W   = (WK_W > COUNT_W) ? WK_W : COUNT_W;

	state_t state_q, state_d;

	logic [RADIUS_W-1:0] radius_q;
	logic [NUMPTS_W-1:0] num_q;

	logic [IDX_W-1:0]      idx_q;
	logic                  ctr_ok_q;
	logic [WK_W-1:0]       walk_q;
	logic [WK_W-1:0]       wcnt_q;
	logic [COORD_BITS-1:0] cx_q, cy_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [WK_W-1:0]       count_q;
	logic signed [VALUE_BITS-1:0] mean_q;

	logic                       v_s1, v_s2, v_s3;
	logic [SQ_W-1:0]            dx2_s2, dy2_s2;
	logic signed [VALUE_BITS-1:0] val_s2, val_s3;
	logic                       hit_s3;

	logic                  out_valid_q;
	logic signed [VALUE_BITS-1:0] smoothed_q;
	logic [COUNT_W-1:0]    ncount_q;
	logic                  empty_q;

	logic                  in_acc;
	logic                  ram_we;
	logic [IDX_W-1:0]      rd_addr;
	logic [ENT_W-1:0]      rdata;
	logic                  div_start;
	logic                  div_done;
	logic signed [SUM_W-1:0] div_quo;
	logic                  out_load;
	logic                  pipe_busy;
	logic                  idx_in_ok;
	logic [WK_W-1:0]       walk_in;
	logic [COORD_BITS-1:0] rx, ry, dx, dy;
	logic signed [VALUE_BITS-1:0] rv;
	logic [CMP_W-1:0]      dist_s2;
	logic [CX_W-1:0]       cnt_x;
	logic [COUNT_W-1:0]    cnt_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign idx_in_ok = {1'b0, point_index} < WK_W'(MAX_POINTS);
	assign ram_we    = in_acc && (req_type == REQ_LOAD) && idx_in_ok;
	assign pipe_busy = v_s1 || v_s2 || v_s3;

	always_comb begin
		walk_in = (WX_W'(num_q) > WX_W'(MAX_POINTS)) ? WK_W'(MAX_POINTS) : WK_W'(num_q);
	end

	rnm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_POINTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (point_index),
		.wdata ({coord_x, coord_y, sample_value}),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	rnm_div #(
		.NUM_W (SUM_W),
		.DEN_W (WK_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_q),
		.den    (count_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			num_q    <= NUMPTS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS_SQ:  radius_q <= cfg_data;
				REG_NUM_POINTS: num_q    <= cfg_data[NUMPTS_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rd_addr   = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && req_type == REQ_QUERY) state_d = ST_CENTER;
			end
			ST_CENTER: begin
				rd_addr = ctr_ok_q ? idx_q : '0;
				state_d = ST_LATCH;
			end
			ST_LATCH: begin
				state_d = (ctr_ok_q && walk_q != '0) ? ST_WALK : ST_DRAIN;
			end
			ST_WALK: begin
				rd_addr = wcnt_q[IDX_W-1:0];
				if (wcnt_q == walk_q - WK_W'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					if (count_q == '0) begin
						state_d = ST_DONE;
					end else begin
						div_start = 1'b1;
						state_d   = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// query bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q  <= '0;
			count_q <= '0;
			wcnt_q  <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_WALK);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (in_acc && req_type == REQ_QUERY) begin
				walk_q  <= walk_in;
				count_q <= '0;
			end else if (v_s3 && hit_s3) begin
				count_q <= count_q + WK_W'(1);
			end
			if (state_q == ST_LATCH) begin
				wcnt_q <= '0;
			end else if (state_q == ST_WALK) begin
				wcnt_q <= wcnt_q + WK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_QUERY) begin
			idx_q    <= point_index;
			ctr_ok_q <= idx_in_ok;
			sum_q    <= '0;
		end else if (v_s3 && hit_s3) begin
			sum_q <= sum_q + SUM_W'(val_s3);
		end
		if (state_q == ST_LATCH) begin
			cx_q <= rdata[ENT_W-1 -: COORD_BITS];
			cy_q <= rdata[VALUE_BITS +: COORD_BITS];
		end
		if (div_done) begin
			mean_q <= div_quo[VALUE_BITS-1:0];
		end
	end

	// distance pipeline: squares, then sum and compare
	always_comb begin
		rx      = rdata[ENT_W-1 -: COORD_BITS];
		ry      = rdata[VALUE_BITS +: COORD_BITS];
		rv      = rdata[VALUE_BITS-1:0];
		dx      = (cx_q >= rx) ? cx_q - rx : rx - cx_q;
		dy      = (cy_q >= ry) ? cy_q - ry : ry - cy_q;
		dist_s2 = CMP_W'({1'b0, dx2_s2} + {1'b0, dy2_s2});
	end

	always_ff @(posedge clk) begin
		dx2_s2 <= SQ_W'(dx) * SQ_W'(dx);
		dy2_s2 <= SQ_W'(dy) * SQ_W'(dy);
		val_s2 <= rv;
		hit_s3 <= dist_s2 < CMP_W'(radius_q);
		val_s3 <= val_s2;
	end

	// output register
	always_comb begin
		cnt_x   = CX_W'(count_q);
		cnt_sat = (cnt_x > CX_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			smoothed_q <= (count_q == '0) ? '0 : mean_q;
			ncount_q   <= cnt_sat;
			empty_q    <= (count_q == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign smoothed_value = smoothed_q;
	assign neighbor_count = ncount_q;
	assign empty_flag     = empty_q;

`ifndef SYNTHESIS
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (empty_flag == (neighbor_count == '0)))
		else $error("empty flag disagrees with neighbor count");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && empty_flag) |-> (smoothed_value == '0))
		else $error("empty result carries a nonzero mean");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= walk_q)
		else $error("neighbor count exceeds walk length");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (wcnt_q < walk_q))
		else $error("walk read past last entry");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside divide state");
`endif

endmodule

`default_nettype wire

### bench/radius_neighborhood_mean_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radius_neighborhood_mean_test
// Drives loads and queries into the neighborhood mean filter under random
// sender bursts and receiver stalls. Local copies of point table and registers
// predict results lacking a fixed expectation; each is checked field by field.
// ----------------------------------------------------------------------------

module radius_neighborhood_mean_test
	import rnm_pkg::*;
;

	localparam int MAX_POINTS   = 1024;
	localparam int IDX_W        = 10;
	localparam int COORD_BITS   = 12;
	localparam int VALUE_BITS   = 24;
	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_AT      = 30;
	localparam int HOLD_CYCLES  = 600;
	localparam logic [RADIUS_W-1:0] RADIUS_ALL = '1;
	localparam logic [RADIUS_W-1:0] RADIUS_FAR = 25'd33538050;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] mean;
		logic        [COUNT_W-1:0]    count;
		logic                         empty;
	} mean_result_t;

	typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

	typedef struct {
		row_kind_t                    kind;
		cfg_reg_t                     reg_sel;
		logic        [RADIUS_W-1:0]   data;
		req_kind_t                    req;
		logic        [IDX_W-1:0]      idx;
		logic        [COORD_BITS-1:0] x;
		logic        [COORD_BITS-1:0] y;
		logic signed [VALUE_BITS-1:0] v;
		bit                           typed;
		mean_result_t                 want;
	} dir_row_t;

	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         in_valid       = 1'b0;
	logic                         in_ready;
	logic                         req_type       = REQ_LOAD;
	logic        [IDX_W-1:0]      point_index    = '0;
	logic        [COORD_BITS-1:0] coord_x        = '0;
	logic        [COORD_BITS-1:0] coord_y        = '0;
	logic signed [VALUE_BITS-1:0] sample_value   = '0;
	logic                         out_valid;
	logic                         out_ready      = 1'b0;
	logic signed [VALUE_BITS-1:0] smoothed_value;
	logic        [COUNT_W-1:0]    neighbor_count;
	logic                         empty_flag;
	logic                         cfg_valid      = 1'b0;
	logic                         cfg_ready;
	logic        [CFG_IDX_W-1:0]  cfg_index      = '0;
	logic        [RADIUS_W-1:0]   cfg_data       = '0;

	// predictor state
	logic        [COORD_BITS-1:0] tbl_x [MAX_POINTS];
	logic        [COORD_BITS-1:0] tbl_y [MAX_POINTS];
	logic signed [VALUE_BITS-1:0] tbl_val [MAX_POINTS];
	bit                           loaded [MAX_POINTS];
	logic        [RADIUS_W-1:0]   cur_radius = RADIUS_RST;
	logic        [NUMPTS_W-1:0]   cur_walk   = NUMPTS_RST;

	mean_result_t pending_means[$];
	dir_row_t     directed_rows[$];
	int           errors       = 0;
	int           results_seen = 0;
	int           burst_left   = 0;
	int           cluster_x    = 0;
	int           cluster_y    = 0;

	int  hold_left   = 0;
	bit  hold_done   = 1'b0;
	int  stall_mode  = 0;
	int  mode_left   = 0;

	radius_neighborhood_mean dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.point_index    (point_index),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.sample_value   (sample_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.smoothed_value (smoothed_value),
		.neighbor_count (neighbor_count),
		.empty_flag     (empty_flag),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic mean_result_t neighborhood_mean(input logic [IDX_W-1:0] center);
		mean_result_t r;
		longint       sum;
		longint       cnt;
		longint       dx;
		longint       dy;
		longint       walk;
		longint       mean;
		sum  = 0;
		cnt  = 0;
		mean = 0;
		walk = (cur_walk > MAX_POINTS) ? MAX_POINTS : cur_walk;
		for (int i = 0; i < walk; i++) begin
			dx = longint'(tbl_x[center]) - longint'(tbl_x[i]);
			dy = longint'(tbl_y[center]) - longint'(tbl_y[i]);
			if (dx * dx + dy * dy < longint'(cur_radius)) begin
				cnt++;
				sum += longint'(tbl_val[i]);
			end
		end
		if (cnt != 0)
			mean = sum / cnt;
		r.mean  = mean[VALUE_BITS-1:0];
		r.count = (cnt > longint'(COUNT_MAX)) ? COUNT_MAX : cnt[COUNT_W-1:0];
		r.empty = (cnt == 0);
		return r;
	endfunction

	function automatic dir_row_t cfg_row(input cfg_reg_t sel, input logic [RADIUS_W-1:0] d);
		dir_row_t r;
		r.kind    = ROW_CFG;
		r.reg_sel = sel;
		r.data    = d;
		r.req     = REQ_LOAD;
		r.idx     = '0;
		r.x       = '0;
		r.y       = '0;
		r.v       = '0;
		r.typed   = 1'b0;
		r.want    = '0;
		return r;
	endfunction

	function automatic dir_row_t req_row(input req_kind_t req, input logic [IDX_W-1:0] idx,
			input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input logic signed [VALUE_BITS-1:0] v, input bit typed,
			input mean_result_t want);
		dir_row_t r;
		r.kind    = ROW_REQ;
		r.reg_sel = REG_RADIUS_SQ;
		r.data    = '0;
		r.req     = req;
		r.idx     = idx;
		r.x       = x;
		r.y       = y;
		r.v       = v;
		r.typed   = typed;
		r.want    = want;
		return r;
	endfunction

	task automatic send_req(input req_kind_t kind, input logic [IDX_W-1:0] idx,
			input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
			input logic signed [VALUE_BITS-1:0] v, input bit typed,
			input mean_result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid     <= 1'b1;
		req_type     <= kind;
		point_index  <= idx;
		coord_x      <= x;
		coord_y      <= y;
		sample_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (kind == REQ_LOAD) begin
			tbl_x[idx]   = x;
			tbl_y[idx]   = y;
			tbl_val[idx] = v;
			loaded[idx]  = 1'b1;
		end else begin
			pending_means.push_back(typed ? want : neighborhood_mean(idx));
		end
	endtask

	// drop valid and let the block go idle before touching a register
	task automatic write_reg(input cfg_reg_t sel, input logic [RADIUS_W-1:0] d);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (sel == REG_RADIUS_SQ)
			cur_radius = d;
		else
			cur_walk = d[NUMPTS_W-1:0];
	endtask

	task automatic send_load(input logic [IDX_W-1:0] idx);
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		if ($urandom_range(0, 9) < 6) begin
			x = COORD_BITS'(cluster_x + $urandom_range(0, 31));
			y = COORD_BITS'(cluster_y + $urandom_range(0, 31));
		end else begin
			x = COORD_BITS'($urandom_range(0, 4095));
			y = COORD_BITS'($urandom_range(0, 4095));
		end
		send_req(REQ_LOAD, idx, x, y, VALUE_BITS'($urandom), 1'b0, '0);
	endtask

	task automatic send_query(input int walk);
		logic [IDX_W-1:0] idx;
		int               tries;
		idx = IDX_W'($urandom_range(0, (walk > 0) ? walk - 1 : 0));
		if ($urandom_range(0, 9) < 3) begin
			tries = 0;
			do begin
				idx = IDX_W'($urandom_range(0, MAX_POINTS - 1));
				tries++;
			end while (!loaded[idx] && tries < 8);
			if (!loaded[idx])
				idx = '0;
		end
		send_req(REQ_QUERY, idx, COORD_BITS'($urandom), COORD_BITS'($urandom),
			VALUE_BITS'($urandom), 1'b0, '0);
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		mean_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected result mean %0d count %0d empty %0b", $realtime,
					smoothed_value, neighbor_count, empty_flag);
				errors++;
			end else begin
				want = pending_means.pop_front();
				if (smoothed_value !== want.mean) begin
					$display("%0t: smoothed_value expected %0d got %0d", $realtime,
						want.mean, smoothed_value);
					errors++;
				end
				if (neighbor_count !== want.count) begin
					$display("%0t: neighbor_count expected %0d got %0d", $realtime,
						want.count, neighbor_count);
					errors++;
				end
				if (empty_flag !== want.empty) begin
					$display("%0t: empty_flag expected %0b got %0b", $realtime,
						want.empty, empty_flag);
					errors++;
				end
			end
		end
	end

	// receiver: one long hold-off, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && results_seen == HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left  <= $urandom_range(16, 128);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		#10ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int walk;
		int eff;
		int items;
		int random_items;
		logic [RADIUS_W-1:0] radius;
		random_items = 0;

		directed_rows.push_back(cfg_row(REG_NUM_POINTS, 25'd4));
		directed_rows.push_back(cfg_row(REG_RADIUS_SQ, 25'd0));
		directed_rows.push_back(req_row(REQ_LOAD, 10'd0, 12'd0, 12'd0, -24'sd8388608, 1'b0,
			'0));
		directed_rows.push_back(req_row(REQ_LOAD, 10'd1, 12'd4095, 12'd4095, 24'sd8388607,
			1'b0, '0));
		directed_rows.push_back(req_row(REQ_LOAD, 10'd2, 12'd0, 12'd1, 24'sd8388607, 1'b0,
			'0));
		directed_rows.push_back(req_row(REQ_LOAD, 10'd3, 12'd4095, 12'd0, -24'sd1, 1'b0, '0));
		// zero radius: nobody is a neighbor, not even the center
		directed_rows.push_back(req_row(REQ_QUERY, 10'd0, 12'd4095, 12'd4095, -24'sd1, 1'b1,
			'{mean: 24'sd0, count: 11'd0, empty: 1'b1}));
		directed_rows.push_back(cfg_row(REG_RADIUS_SQ, 25'd1));
		directed_rows.push_back(req_row(REQ_QUERY, 10'd0, 12'd0, 12'd0, 24'sd0, 1'b1,
			'{mean: -24'sd8388608, count: 11'd1, empty: 1'b0}));
		directed_rows.push_back(req_row(REQ_QUERY, 10'd1, 12'hAAA, 12'h555, 24'sh5A5A5A, 1'b1,
			'{mean: 24'sd8388607, count: 11'd1, empty: 1'b0}));
		directed_rows.push_back(cfg_row(REG_RADIUS_SQ, 25'd2));
		directed_rows.push_back(req_row(REQ_QUERY, 10'd0, 12'd0, 12'd0, 24'sd0, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_RADIUS_SQ, RADIUS_ALL));
		directed_rows.push_back(req_row(REQ_QUERY, 10'd3, 12'd0, 12'd0, 24'sd0, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_RADIUS_SQ, RADIUS_FAR));
		directed_rows.push_back(req_row(REQ_QUERY, 10'd0, 12'd0, 12'd0, 24'sd0, 1'b0, '0));
		// center outside the walked range
		directed_rows.push_back(cfg_row(REG_NUM_POINTS, 25'd3));
		directed_rows.push_back(req_row(REQ_QUERY, 10'd3, 12'd0, 12'd0, 24'sd0, 1'b0, '0));
		directed_rows.push_back(cfg_row(REG_NUM_POINTS, 25'd0));
		directed_rows.push_back(req_row(REQ_QUERY, 10'd1, 12'd0, 12'd0, 24'sd0, 1'b1,
			'{mean: 24'sd0, count: 11'd0, empty: 1'b1}));
		directed_rows.push_back(cfg_row(REG_NUM_POINTS, 25'd1));
		directed_rows.push_back(req_row(REQ_QUERY, 10'd0, 12'd0, 12'd0, 24'sd0, 1'b0, '0));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG)
				write_reg(directed_rows[i].reg_sel, directed_rows[i].data);
			else
				send_req(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].x,
					directed_rows[i].y, directed_rows[i].v, directed_rows[i].typed,
					directed_rows[i].want);
		end

		// random phases: fill the walked prefix first so no unwritten entry is read
		while (random_items < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: walk = 0;
				1: walk = 1;
				2: walk = $urandom_range(49, 160);
				default: walk = $urandom_range(2, 48);
			endcase
			case ($urandom_range(0, 9))
				0: radius = '0;
				1: radius = 25'd1;
				2: radius = RADIUS_ALL;
				3: radius = RADIUS_FAR;
				4, 5, 6, 7: radius = RADIUS_W'($urandom_range(2, 2048));
				default: radius = RADIUS_W'($urandom_range(0, 33554431));
			endcase
			write_reg(REG_NUM_POINTS, RADIUS_W'(walk));
			write_reg(REG_RADIUS_SQ, radius);
			cluster_x = $urandom_range(0, 4095 - 31);
			cluster_y = $urandom_range(0, 4095 - 31);
			eff = walk;
			for (int i = 0; i < eff; i++)
				if (!loaded[i]) begin
					send_load(IDX_W'(i));
					random_items++;
				end
			items = $urandom_range(30, 70);
			repeat (items) begin
				if ($urandom_range(0, 9) < 6) begin
					if ($urandom_range(0, 9) < 7 && eff > 0)
						send_load(IDX_W'($urandom_range(0, eff - 1)));
					else
						send_load(IDX_W'($urandom_range(0, MAX_POINTS - 1)));
				end else begin
					send_query(eff);
				end
				random_items++;
			end
		end

		in_valid <= 1'b0;
		while (pending_means.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/rnm_pkg.sv
rtl/rnm_ram.sv
rtl/rnm_div.sv
rtl/radius_neighborhood_mean.sv
bench/radius_neighborhood_mean_test.sv
